[sv/cmcs_pkg.sv]
`default_nettype none

package cmcs_pkg;

   // Map geometry; the map size must be a power of two
   localparam int MAP_ENTRIES = 1024;
   localparam int MAP_AW      = $clog2(MAP_ENTRIES);

   // Field widths
   localparam int POS_W      = 16;
   localparam int DATA_W     = 16;
   localparam int IDX_W      = 10;
   localparam int DIV_W      = 16;
   localparam int GAP_W      = 10;
   localparam int STEP_W     = 14;
   localparam int CSR_IDX_W  = 4;
   localparam int CSR_DATA_W = 16;

   // Q0.16 position: low bits below the map index, and one step
   localparam int FRAC_W = POS_W - MAP_AW;
   localparam logic [POS_W-1:0]  STEP_SIZE = POS_W'(1) << FRAC_W;
   localparam logic [FRAC_W-1:0] HALF_LSB  = FRAC_W'(1) << (FRAC_W - 1);

   // Register reset values
   localparam logic [DIV_W-1:0] TICK_DIV_RESET = DIV_W'(500);
   localparam logic [GAP_W-1:0] GAP_RESET      = GAP_W'(100);

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_TICK_DIV = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_GAP      = CSR_IDX_W'(1);

   // Item modes
   typedef enum logic [1:0] {
      MODE_TICK  = 2'd0,
      MODE_START = 2'd1,
      MODE_READ  = 2'd2,
      MODE_STOP  = 2'd3
   } mode_type;

   // Step decision and sequencer state, sequencer to top level
   typedef struct packed {
      logic               cw_sample;
      logic               ccw_sample;
      logic               done;
      logic [MAP_AW-1:0]  map_idx;
      logic [POS_W-1:0]   position;
      logic [POS_W-1:0]   pos_next;
      logic               calibrated;
      logic               calibrated_next;
   } seq_type;

   // One result beat
   typedef struct packed {
      logic [POS_W-1:0]         position_ref;
      logic                     report_valid;
      logic [IDX_W-1:0]         report_index;
      logic signed [DATA_W-1:0] report_value;
      logic                     finished;
      logic                     map_valid;
      logic signed [DATA_W-1:0] map_value;
      logic                     disarm;
   } rsp_type;

endpackage

`default_nettype wire

[sv/cmcs_if.sv]
`default_nettype none

// Request channel
interface cmcs_req_if;
   import cmcs_pkg::*;
   logic                     valid;
   logic                     ready;
   logic [1:0]               mode;
   logic signed [DATA_W-1:0] iq_scaled;
   logic [POS_W-1:0]         start_position;
   logic [IDX_W-1:0]         read_index;

   modport source (output valid, mode, iq_scaled, start_position, read_index, input ready);
   modport sink (input valid, mode, iq_scaled, start_position, read_index, output ready);
endinterface

// Response channel
interface cmcs_rsp_if;
   import cmcs_pkg::*;
   logic                     valid;
   logic                     ready;
   logic [POS_W-1:0]         position_ref;
   logic                     report_valid;
   logic [IDX_W-1:0]         report_index;
   logic signed [DATA_W-1:0] report_value;
   logic                     finished;
   logic                     map_valid;
   logic signed [DATA_W-1:0] map_value;
   logic                     disarm;

   modport source (output valid, position_ref, report_valid, report_index, report_value,
                   finished, map_valid, map_value, disarm, input ready);
   modport sink (input valid, position_ref, report_valid, report_index, report_value,
                 finished, map_valid, map_value, disarm, output ready);
endinterface

// Register write channel
interface cmcs_csr_if;
   import cmcs_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

[sv/cogging_map_calibration_sequencer.sv]
`default_nettype none

// Cogging map calibration sequencer. One request beat gives one response
// beat. Ticks, starts, stops and clockwise samples go to the output
// register directly; counter-clockwise samples and map reads first pass
// through the merge or read state, since the map sits in a RAM with a
// registered read and the averaged entry is written back in the merge state.
// After reset, a start, or a stop of a map not yet complete, a clearing pass
// writes zero to all MAP_ENTRIES entries, one per cycle, and no request is
// taken meanwhile; register writes are taken at any time. A request is taken
// only when idle, with the previous response taken in that cycle or earlier.
module cogging_map_calibration_sequencer (
   input wire logic  clock,
   input wire logic  reset,
   cmcs_req_if.sink   req_bus,
   cmcs_rsp_if.source rsp_bus,
   cmcs_csr_if.sink   csr_bus
);
   import cmcs_pkg::*;

   typedef enum logic [3:0] {
      ST_CLEAR = 4'b0001,
      ST_IDLE  = 4'b0010,
      ST_MERGE = 4'b0100,
      ST_READ  = 4'b1000
   } state_type;

   state_type                state_ff, state_in;
   logic [MAP_AW-1:0]        clr_addr_ff, clr_addr_in;
   logic [MAP_AW-1:0]        idx_ff, idx_in;
   logic signed [DATA_W-1:0] sample_ff, sample_in;
   logic                     oob_ff, oob_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   rsp_type                  rsp_data_ff, rsp_in;
   logic                     rsp_load;

   logic                     req_ready;
   logic                     accept;
   mode_type                 mode;
   seq_type                  seq;

   logic                     ram_we, ram_re;
   logic [MAP_AW-1:0]        ram_waddr, ram_raddr;
   logic [DATA_W-1:0]        ram_wdata, ram_rdata;
   logic signed [DATA_W:0]   sum_w, adj_w;

   // Handshake
   assign req_ready     = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_bus.ready);
   assign req_bus.ready = req_ready;
   assign accept        = req_bus.valid && req_ready;
   assign mode          = mode_type'(req_bus.mode);
   assign csr_bus.ready = 1'b1;

   cmcs_seq u_seq (
      .clock          (clock),
      .reset          (reset),
      .csr_we         (csr_bus.valid),
      .csr_index      (csr_bus.index),
      .csr_data       (csr_bus.data),
      .item_accept    (accept),
      .item_mode      (mode),
      .start_position (req_bus.start_position),
      .seq            (seq)
   );

   cmcs_ram #(
      .WIDTH (DATA_W),
      .DEPTH (MAP_ENTRIES)
   ) u_map (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (ram_re),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   // Counter-clockwise merge: (stored + sample) / 2 toward zero
   always_comb begin
      sum_w = {ram_rdata[DATA_W-1], ram_rdata} + {sample_ff[DATA_W-1], sample_ff};
      adj_w = sum_w + (DATA_W+1)'(sum_w[DATA_W]);
   end

   // Map port selection
   always_comb begin
      ram_we    = 1'b0;
      ram_waddr = seq.map_idx;
      ram_wdata = req_bus.iq_scaled;
      ram_re    = 1'b0;
      ram_raddr = seq.map_idx;
      case (state_ff)
         ST_CLEAR: begin
            ram_we    = 1'b1;
            ram_waddr = clr_addr_ff;
            ram_wdata = '0;
         end
         ST_IDLE: begin
            if (accept && mode == MODE_TICK) begin
               ram_we = seq.cw_sample;
               ram_re = seq.ccw_sample;
            end
            if (accept && mode == MODE_READ) begin
               ram_re    = 1'b1;
               ram_raddr = MAP_AW'(req_bus.read_index);
            end
         end
         ST_MERGE: begin
            ram_we    = 1'b1;
            ram_waddr = idx_ff;
            ram_wdata = adj_w[DATA_W:1];
         end
         default: begin
         end
      endcase
   end

   // Control sequence and response assembly
   always_comb begin
      state_in            = state_ff;
      clr_addr_in         = clr_addr_ff;
      idx_in              = idx_ff;
      sample_in           = sample_ff;
      oob_in              = oob_ff;
      rsp_load            = 1'b0;
      rsp_in              = '0;
      rsp_in.position_ref = seq.pos_next;
      rsp_in.map_valid    = seq.calibrated_next;
      case (state_ff)
         ST_CLEAR: begin
            clr_addr_in = clr_addr_ff + MAP_AW'(1);
            if (clr_addr_ff == '1) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               idx_in    = seq.map_idx;
               sample_in = req_bus.iq_scaled;
               oob_in    = 32'(req_bus.read_index) >= MAP_ENTRIES;
               case (mode)
                  MODE_TICK: begin
                     rsp_in.report_valid = seq.cw_sample;
                     rsp_in.report_index = seq.cw_sample ? IDX_W'(seq.map_idx) : '0;
                     rsp_in.report_value = seq.cw_sample ? req_bus.iq_scaled : '0;
                     rsp_in.finished     = seq.done;
                     rsp_load            = !seq.ccw_sample;
                     if (seq.ccw_sample) begin
                        state_in = ST_MERGE;
                     end
                  end
                  MODE_START: begin
                     rsp_load = 1'b1;
                     state_in = ST_CLEAR;
                  end
                  MODE_READ: begin
                     state_in = ST_READ;
                  end
                  MODE_STOP: begin
                     rsp_in.disarm = 1'b1;
                     rsp_load      = 1'b1;
                     if (!seq.calibrated) begin
                        state_in = ST_CLEAR;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_MERGE: begin
            rsp_in.position_ref = seq.position;
            rsp_in.map_valid    = seq.calibrated;
            rsp_in.report_valid = 1'b1;
            rsp_in.report_index = IDX_W'(idx_ff);
            rsp_in.report_value = sample_ff;
            rsp_load            = 1'b1;
            state_in            = ST_IDLE;
         end
         ST_READ: begin
            rsp_in.position_ref = seq.position;
            rsp_in.map_valid    = seq.calibrated;
            rsp_in.map_value    = oob_ff ? '0 : ram_rdata;
            rsp_load            = 1'b1;
            state_in            = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      rsp_valid_in = rsp_load || (rsp_valid_ff && !rsp_bus.ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_addr_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff    <= idx_in;
      sample_ff <= sample_in;
      oob_ff    <= oob_in;
      if (rsp_load) begin
         rsp_data_ff <= rsp_in;
      end
   end

   // Response beat
   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.position_ref = rsp_data_ff.position_ref;
   assign rsp_bus.report_valid = rsp_data_ff.report_valid;
   assign rsp_bus.report_index = rsp_data_ff.report_index;
   assign rsp_bus.report_value = rsp_data_ff.report_value;
   assign rsp_bus.finished     = rsp_data_ff.finished;
   assign rsp_bus.map_valid    = rsp_data_ff.map_valid;
   assign rsp_bus.map_value    = rsp_data_ff.map_value;
   assign rsp_bus.disarm       = rsp_data_ff.disarm;

`ifndef NO_ASSERTIONS
   // The merge write-back state is always followed by the idle state
   a_merge_one_cycle: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_MERGE |=> state_ff == ST_IDLE)
      else $error("merge state did not return to idle");

   // A new response never overwrites one that has not been taken
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      rsp_load && rsp_valid_ff |-> rsp_bus.ready)
      else $error("response register overwritten");

   // Every clearing pass runs to the last entry before requests resume
   a_clear_complete: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_IDLE |-> clr_addr_ff == '0)
      else $error("clearing pass left incomplete");

   // A start always clears the map
   a_start_clears: assert property (@(posedge clock) disable iff (reset)
      accept && mode == MODE_START |=> state_ff == ST_CLEAR)
      else $error("start did not begin a clearing pass");
`endif

endmodule

`default_nettype wire

[sv/cmcs_ram.sv]
`default_nettype none

// Single write port, single registered read port
module cmcs_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata <= mem[raddr];
      end
   end

endmodule

`default_nettype wire

[sv/cmcs_seq.sv]
`default_nettype none

// Step sequencer: prescaler, step counter, position reference, run flags
// and the two calibration registers. Next values are offered for the
// current request and taken when the top level accepts it.
module cmcs_seq (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_we,
   input  logic [cmcs_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [cmcs_pkg::CSR_DATA_W-1:0]    csr_data,
   input  logic                               item_accept,
   input  cmcs_pkg::mode_type                 item_mode,
   input  logic [cmcs_pkg::POS_W-1:0]         start_position,
   output cmcs_pkg::seq_type                  seq
);
   import cmcs_pkg::*;

   logic [DIV_W-1:0]  tick_div_ff, tick_div_in;
   logic [GAP_W-1:0]  gap_ff, gap_in;
   logic [DIV_W-1:0]  tick_count_ff, tick_count_in;
   logic [STEP_W-1:0] step_count_ff, step_count_in;
   logic [POS_W-1:0]  position_ff, position_in;
   logic              calibrated_ff, calibrated_in;
   logic              running_ff, running_in;

   logic [DIV_W-1:0]  tick_inc;
   logic [STEP_W-1:0] step_inc;
   logic [STEP_W-1:0] lim_cw_gap, lim_cw_smp, lim_ccw_gap, lim_ccw_smp;
   logic              advance, cw_gap, cw_smp, ccw_gap, ccw_smp, done;
   logic [MAP_AW-1:0] idx_q;
   logic [FRAC_W-1:0] idx_r;
   logic              round_up;

   // Register writes; unknown indexes are dropped
   always_comb begin
      tick_div_in = tick_div_ff;
      gap_in      = gap_ff;
      if (csr_we && csr_index == CSR_TICK_DIV) begin
         tick_div_in = csr_data[DIV_W-1:0];
      end
      if (csr_we && csr_index == CSR_GAP) begin
         gap_in = csr_data[GAP_W-1:0];
      end
   end

   // Phase boundaries from the current gap setting
   always_comb begin
      lim_cw_gap  = STEP_W'(gap_ff);
      lim_cw_smp  = lim_cw_gap + STEP_W'(MAP_ENTRIES);
      lim_ccw_gap = lim_cw_smp + STEP_W'(gap_ff);
      lim_ccw_smp = lim_ccw_gap + STEP_W'(MAP_ENTRIES);
   end

   // Prescaler and phase decode; a zero divider steps on every tick
   always_comb begin
      tick_inc = tick_count_ff + DIV_W'(1);
      step_inc = step_count_ff + STEP_W'(1);
      advance  = running_ff && (item_mode == MODE_TICK) && (tick_inc >= tick_div_ff);
      cw_gap   = step_inc <= lim_cw_gap;
      cw_smp   = !cw_gap && (step_inc <= lim_cw_smp);
      ccw_gap  = !cw_gap && !cw_smp && (step_inc <= lim_ccw_gap);
      ccw_smp  = !cw_gap && !cw_smp && !ccw_gap && (step_inc <= lim_ccw_smp);
      done     = !cw_gap && !cw_smp && !ccw_gap && !ccw_smp;
   end

   // Map index: N * position / 2^16, rounded half to even, N wraps to 0
   always_comb begin
      idx_q    = position_ff[POS_W-1:FRAC_W];
      idx_r    = position_ff[FRAC_W-1:0];
      round_up = (idx_r > HALF_LSB) || (idx_r == HALF_LSB && idx_q[0]);
   end

   // Next state for the offered request
   always_comb begin
      tick_count_in = tick_count_ff;
      step_count_in = step_count_ff;
      position_in   = position_ff;
      calibrated_in = calibrated_ff;
      running_in    = running_ff;
      case (item_mode)
         MODE_TICK: begin
            if (running_ff) begin
               tick_count_in = advance ? '0 : tick_inc;
            end
            if (advance) begin
               step_count_in = done ? '0 : step_inc;
               if (cw_gap || cw_smp) begin
                  position_in = position_ff + STEP_SIZE;
               end else if (ccw_gap || ccw_smp) begin
                  position_in = position_ff - STEP_SIZE;
               end
               if (done) begin
                  calibrated_in = 1'b1;
                  running_in    = 1'b0;
               end
            end
         end
         MODE_START: begin
            tick_count_in = '0;
            step_count_in = '0;
            calibrated_in = 1'b0;
            position_in   = start_position;
            running_in    = 1'b1;
         end
         MODE_STOP: begin
            running_in = 1'b0;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tick_div_ff   <= TICK_DIV_RESET;
         gap_ff        <= GAP_RESET;
         tick_count_ff <= '0;
         step_count_ff <= '0;
         position_ff   <= '0;
         calibrated_ff <= 1'b0;
         running_ff    <= 1'b0;
      end else begin
         tick_div_ff <= tick_div_in;
         gap_ff      <= gap_in;
         if (item_accept) begin
            tick_count_ff <= tick_count_in;
            step_count_ff <= step_count_in;
            position_ff   <= position_in;
            calibrated_ff <= calibrated_in;
            running_ff    <= running_in;
         end
      end
   end

   always_comb begin
      seq.cw_sample       = advance && cw_smp;
      seq.ccw_sample      = advance && ccw_smp;
      seq.done            = advance && done;
      seq.map_idx         = idx_q + MAP_AW'(round_up);
      seq.position        = position_ff;
      seq.pos_next        = position_in;
      seq.calibrated      = calibrated_ff;
      seq.calibrated_next = calibrated_in;
   end

endmodule

`default_nettype wire

[tb/tb_cogging_map_calibration_sequencer.sv]
`timescale 1ns / 1ps

module tb_cogging_map_calibration_sequencer;
   import cmcs_pkg::*;

   // Register index the block does not decode
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = CSR_IDX_W'(15);
   localparam int HOLD_CYCLES   = 300;
   localparam int SHOW_MISMATCH = 10;

   typedef struct {
      mode_type                 mode;
      logic signed [DATA_W-1:0] iq;
      logic [POS_W-1:0]         spos;
      logic [IDX_W-1:0]         ridx;
   } req_beat_type;

   typedef struct {
      mode_type         mode;
      logic [DATA_W-1:0] iq;
      logic [POS_W-1:0] spos;
      logic [IDX_W-1:0] ridx;
      bit               typed;
      logic [POS_W-1:0] want_pos;
      bit               want_disarm;
   } dir_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   cmcs_req_if req_bus ();
   cmcs_rsp_if rsp_bus ();
   cmcs_csr_if csr_bus ();

   cogging_map_calibration_sequencer dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Shadow of the sequencer state and its registers
   logic [DIV_W-1:0]         cfg_div = TICK_DIV_RESET;
   logic [GAP_W-1:0]         cfg_gap = GAP_RESET;
   logic [DIV_W-1:0]         tick_cnt = '0;
   logic [STEP_W-1:0]        step_cnt = '0;
   logic [POS_W-1:0]         pos = '0;
   logic signed [DATA_W-1:0] cog_shadow [MAP_ENTRIES];
   bit                       calib_done = 1'b0;
   bit                       sweeping = 1'b0;

   rsp_type owed_responses [$];

   int send_idle_pct = 35;
   int recv_idle_pct = 69;
   int hold_requests = 0;
   int holds_served  = 0;
   int hold_left     = 0;
   int errors        = 0;
   int beats_sent    = 0;
   int samples_seen  = 0;
   int finishes_seen = 0;

   // Directed rows: typed expectations only where obvious, others predicted
   dir_row_type directed_rows [22] = '{
      '{MODE_TICK,  16'h7fff, 16'hffff, 10'h3ff, 1'b1, 16'h0000, 1'b0},
      '{MODE_READ,  16'h0000, 16'h0000, 10'h000, 1'b1, 16'h0000, 1'b0},
      '{MODE_READ,  16'h8000, 16'h0000, 10'h3ff, 1'b1, 16'h0000, 1'b0},
      '{MODE_STOP,  16'h0000, 16'h0000, 10'h000, 1'b1, 16'h0000, 1'b1},
      '{MODE_START, 16'h8000, 16'hffff, 10'h000, 1'b1, 16'hffff, 1'b0},
      '{MODE_TICK,  16'h8000, 16'h0000, 10'h000, 1'b1, 16'h003f, 1'b0},
      '{MODE_TICK,  16'h7fff, 16'h0000, 10'h000, 1'b0, 16'h0000, 1'b0},
      '{MODE_TICK,  16'h8000, 16'h0000, 10'h000, 1'b0, 16'h0000, 1'b0},
      '{MODE_READ,  16'h0000, 16'h0000, 10'h001, 1'b0, 16'h0000, 1'b0},
      '{MODE_START, 16'h0000, 16'h0020, 10'h000, 1'b0, 16'h0000, 1'b0},
      '{MODE_TICK,  16'h0001, 16'h0000, 10'h000, 1'b0, 16'h0000, 1'b0},
      '{MODE_TICK,  16'hffff, 16'h0000, 10'h000, 1'b0, 16'h0000, 1'b0},
      '{MODE_TICK,  16'h7ffe, 16'h0000, 10'h000, 1'b0, 16'h0000, 1'b0},
      '{MODE_READ,  16'h0000, 16'h0000, 10'h002, 1'b0, 16'h0000, 1'b0},
      '{MODE_STOP,  16'h0000, 16'h0000, 10'h000, 1'b0, 16'h0000, 1'b0},
      '{MODE_READ,  16'h0000, 16'h0000, 10'h002, 1'b0, 16'h0000, 1'b0},
      '{MODE_START, 16'h0000, 16'hffa0, 10'h000, 1'b0, 16'h0000, 1'b0},
      '{MODE_TICK,  16'h1234, 16'h0000, 10'h000, 1'b0, 16'h0000, 1'b0},
      '{MODE_TICK,  16'h5678, 16'h0000, 10'h000, 1'b0, 16'h0000, 1'b0},
      '{MODE_READ,  16'h0000, 16'h0000, 10'h000, 1'b0, 16'h0000, 1'b0},
      '{MODE_STOP,  16'h0000, 16'h0000, 10'h000, 1'b0, 16'h0000, 1'b0},
      '{MODE_TICK,  16'h7fff, 16'h0000, 10'h000, 1'b0, 16'h0000, 1'b0}
   };

   // Q0.16 position to map slot, half to even, top slot wraps to zero
   function automatic logic [IDX_W-1:0] pos_to_index(input logic [POS_W-1:0] p);
      logic [31:0] prod;
      logic [31:0] q;
      logic [15:0] rem;
      prod = 32'(MAP_ENTRIES) * 32'(p);
      q    = prod >> 16;
      rem  = prod[15:0];
      if (rem > 16'h8000 || (rem == 16'h8000 && q[0]))
         q = q + 1;
      if (q >= MAP_ENTRIES)
         q = 0;
      return q[IDX_W-1:0];
   endfunction

   function automatic void clear_shadow_map();
      foreach (cog_shadow[i])
         cog_shadow[i] = '0;
   endfunction

   // Advance the shadow state by one request and return the response it owes
   function automatic rsp_type sequencer_response(input req_beat_type r);
      rsp_type          o;
      int               s;
      int               g;
      int               sum;
      logic [IDX_W-1:0] k;
      o = '0;
      g = int'(cfg_gap);
      case (r.mode)
         MODE_TICK: begin
            if (sweeping) begin
               tick_cnt = tick_cnt + 1'b1;
               if (tick_cnt >= cfg_div) begin
                  tick_cnt = '0;
                  step_cnt = step_cnt + 1'b1;
                  s = int'(step_cnt);
                  k = pos_to_index(pos);
                  if (s <= g) begin
                     pos = pos + STEP_SIZE;
                  end else if (s <= g + MAP_ENTRIES) begin
                     cog_shadow[k]  = r.iq;
                     o.report_valid = 1'b1;
                     o.report_index = k;
                     o.report_value = r.iq;
                     pos = pos + STEP_SIZE;
                  end else if (s <= 2 * g + MAP_ENTRIES) begin
                     pos = pos - STEP_SIZE;
                  end else if (s <= 2 * g + 2 * MAP_ENTRIES) begin
                     // average truncates toward zero
                     sum = int'(cog_shadow[k]) + int'(r.iq);
                     cog_shadow[k]  = DATA_W'(sum / 2);
                     o.report_valid = 1'b1;
                     o.report_index = k;
                     o.report_value = r.iq;
                     pos = pos - STEP_SIZE;
                  end else begin
                     o.finished = 1'b1;
                     calib_done = 1'b1;
                     sweeping   = 1'b0;
                     step_cnt   = '0;
                  end
               end
            end
         end
         MODE_START: begin
            tick_cnt   = '0;
            step_cnt   = '0;
            calib_done = 1'b0;
            clear_shadow_map();
            pos      = r.spos;
            sweeping = 1'b1;
         end
         MODE_READ: begin
            o.map_value = cog_shadow[r.ridx];
         end
         default: begin
            o.disarm = 1'b1;
            sweeping = 1'b0;
            if (!calib_done)
               clear_shadow_map();
         end
      endcase
      o.position_ref = pos;
      o.map_valid    = calib_done;
      return o;
   endfunction

   // Offer one request beat, with random idle cycles in front of it
   task automatic send_beat(input req_beat_type r, input bit typed = 1'b0,
                            input rsp_type want = '0);
      rsp_type pred;
      while ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid          <= 1'b1;
      req_bus.mode           <= r.mode;
      req_bus.iq_scaled      <= r.iq;
      req_bus.start_position <= r.spos;
      req_bus.read_index     <= r.ridx;
      do @(posedge clock); while (!req_bus.ready);
      pred = sequencer_response(r);
      owed_responses.push_back(typed ? want : pred);
      beats_sent++;
   endtask

   // Hold the request side until every owed response has come back
   task automatic drain();
      req_bus.valid <= 1'b0;
      do @(posedge clock); while (owed_responses.size() != 0);
   endtask

   // One register write beat; the caller lowers valid after the last one
   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data  <= data;
      do @(posedge clock); while (!csr_bus.ready);
      if (idx == CSR_TICK_DIV)
         cfg_div = data[DIV_W-1:0];
      else if (idx == CSR_GAP)
         cfg_gap = data[GAP_W-1:0];
   endtask

   task automatic program_regs(input logic [DIV_W-1:0] divider,
                               input logic [GAP_W-1:0] gap);
      csr_write(CSR_TICK_DIV, CSR_DATA_W'(divider));
      csr_write(CSR_GAP, CSR_DATA_W'(gap));
      csr_bus.valid <= 1'b0;
   endtask

   function automatic req_beat_type random_beat(input mode_type m);
      req_beat_type r;
      int           pick;
      r.mode = m;
      pick   = $urandom_range(99);
      r.iq   = (pick < 10) ? ($urandom_range(1) ? 16'sh7fff : 16'sh8000) : DATA_W'($urandom);
      pick   = $urandom_range(99);
      r.spos = POS_W'($urandom);
      // ties between two slots, and starts just below the wrap point
      if (pick < 25)
         r.spos[5:0] = 6'h20;
      else if (pick < 35)
         r.spos[15:8] = 8'hff;
      if ($urandom_range(1))
         r.ridx = IDX_W'($urandom);
      else
         r.ridx = pos_to_index(pos) + IDX_W'($urandom_range(16)) - IDX_W'(8);
      return r;
   endfunction

   // Random sweep traffic: mostly starts followed by ticks, some reads and stops
   task automatic run_chunk(input int want);
      int        counted;
      int        pick;
      mode_type  m;
      counted = 0;
      while (counted < want) begin
         pick = $urandom_range(99);
         if (!sweeping)
            m = (pick < 45) ? MODE_START : (pick < 70) ? MODE_READ :
                (pick < 85) ? MODE_STOP : MODE_TICK;
         else
            m = (pick < 88) ? MODE_TICK : (pick < 95) ? MODE_READ :
                (pick < 97) ? MODE_STOP : MODE_START;
         if (!(m == MODE_TICK && !sweeping))
            counted++;
         send_beat(random_beat(m));
      end
   endtask

   // Full calibration from start to finish, reads around a stop, then a tick and a new start with ticks
   task automatic full_calibration();
      int n;
      n = 0;
      send_beat(random_beat(MODE_START));
      while (sweeping) begin
         if (n == 600)
            hold_requests++;
         send_beat(random_beat(($urandom_range(99) < 4) ? MODE_READ : MODE_TICK));
         n++;
      end
      repeat (12) send_beat(random_beat(MODE_READ));
      send_beat(random_beat(MODE_STOP));
      repeat (12) send_beat(random_beat(MODE_READ));
      send_beat(random_beat(MODE_TICK));
      send_beat(random_beat(MODE_START));
      repeat (4) send_beat(random_beat(MODE_TICK));
   endtask

   task automatic note_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
      if (got !== want) begin
         errors++;
         if (errors <= SHOW_MISMATCH)
            $display("mismatch %s: expected %h, got %h", name, want, got);
      end
   endtask

   // Receiver: random or held ready, and check of each response beat
   always @(posedge clock) begin
      rsp_type got;
      rsp_type want;
      if (hold_requests != holds_served) begin
         holds_served = hold_requests;
         hold_left    = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         got.position_ref = rsp_bus.position_ref;
         got.report_valid = rsp_bus.report_valid;
         got.report_index = rsp_bus.report_index;
         got.report_value = rsp_bus.report_value;
         got.finished     = rsp_bus.finished;
         got.map_valid    = rsp_bus.map_valid;
         got.map_value    = rsp_bus.map_value;
         got.disarm       = rsp_bus.disarm;
         if (owed_responses.size() == 0) begin
            errors++;
            if (errors <= SHOW_MISMATCH)
               $display("response beat with nothing outstanding: %p", got);
         end else begin
            want = owed_responses.pop_front();
            note_field("position_ref", want.position_ref, got.position_ref);
            note_field("report_valid", 16'(want.report_valid), 16'(got.report_valid));
            note_field("report_index", 16'(want.report_index), 16'(got.report_index));
            note_field("report_value", want.report_value, got.report_value);
            note_field("finished", 16'(want.finished), 16'(got.finished));
            note_field("map_valid", 16'(want.map_valid), 16'(got.map_valid));
            note_field("map_value", want.map_value, got.map_value);
            note_field("disarm", 16'(want.disarm), 16'(got.disarm));
            if (want.report_valid)
               samples_seen++;
            if (want.finished)
               finishes_seen++;
         end
      end
   end

   // Run limit
   initial begin
      #10_000_000;
      $display("RESULT: ERROR");
      $finish;
   end

   initial begin
      req_beat_type r;
      rsp_type      want;
      req_bus.valid          = 1'b0;
      req_bus.mode           = MODE_TICK;
      req_bus.iq_scaled      = '0;
      req_bus.start_position = '0;
      req_bus.read_index     = '0;
      csr_bus.valid          = 1'b0;
      csr_bus.index          = CSR_TICK_DIV;
      csr_bus.data           = '0;
      rsp_bus.ready          = 1'b0;
      clear_shadow_map();

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Unknown register first, then one step per tick with a short settle
      csr_write(CSR_UNUSED, 16'hffff);
      program_regs(DIV_W'(1), GAP_W'(1));

      // Directed part
      foreach (directed_rows[i]) begin
         r.mode = directed_rows[i].mode;
         r.iq   = directed_rows[i].iq;
         r.spos = directed_rows[i].spos;
         r.ridx = directed_rows[i].ridx;
         want   = '0;
         want.position_ref = directed_rows[i].want_pos;
         want.disarm       = directed_rows[i].want_disarm;
         send_beat(r, directed_rows[i].typed, want);
      end

      // Sender idles less than receiver; divider zero acts as one
      drain();
      program_regs(DIV_W'(0), GAP_W'(0));
      run_chunk(100);
      drain();
      program_regs(DIV_W'(1), GAP_W'(3));
      hold_requests++;
      run_chunk(100);
      drain();
      program_regs(DIV_W'(2), GAP_W'(1));
      run_chunk(100);

      // Roles swapped; largest divider and settle count first
      drain();
      send_idle_pct = 69;
      recv_idle_pct = 35;
      program_regs(DIV_W'(16'hffff), GAP_W'(10'h3ff));
      run_chunk(100);
      drain();
      program_regs(DIV_W'(1), GAP_W'(10'h3ff));
      hold_requests++;
      run_chunk(100);
      drain();
      program_regs(DIV_W'(3), GAP_W'(2));
      run_chunk(100);

      // Back to back, one complete calibration
      drain();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      program_regs(DIV_W'(1), GAP_W'(2));
      full_calibration();

      drain();
      repeat (10) @(posedge clock);
      $display("Sent %0d requests: %0d map samples reported, %0d calibrations finished,",
               beats_sent, samples_seen, finishes_seen);
      $display("under idle, swapped-idle, held and back-to-back handshakes.");
      if (errors == 0 && owed_responses.size() == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule

[filelist.f]
sv/cmcs_pkg.sv
sv/cmcs_if.sv
sv/cmcs_ram.sv
sv/cmcs_seq.sv
sv/cogging_map_calibration_sequencer.sv
tb/tb_cogging_map_calibration_sequencer.sv
